// File: src/lzbe_pkg.sv
// Shared types and constants for the LZ77 byte encoder.
package lzbe_pkg;

  localparam int LEN_W = 4;
  localparam logic [LEN_W-1:0] MIN_LEN = 4'd3;
  localparam logic [7:0] TOKEN_FLAG = 8'h80;
  localparam logic [15:0] POS_LIMIT = 16'hFFFF;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        block_done;
    logic        overflow;
    logic [15:0] total_length;
  } out_item_t;

  typedef struct packed {
    logic [15:0] output_capacity;
  } cfg_item_t;

  typedef struct packed {
    logic load;
    logic shift_len;
    logic shift_byte;
    len_t avail;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_LOAD,
    S_SCAN,
    S_ENC,
    S_FL_CHK,
    S_FL_HDR,
    S_FL_RD,
    S_FL_EM,
    S_TK_CHK,
    S_TK0,
    S_TK1,
    S_FIN_OUT,
    S_FAIL
  } lzbe_state_t;

  typedef enum logic [1:0] {
    MODE_MATCH,
    MODE_RUN,
    MODE_FINAL
  } lzbe_mode_t;

endpackage

// File: src/lzbe_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface lzbe_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: src/lz77_byte_encoder.sv
// Top level: greedy LZ77 encoder with a systolic match chain, literal runs and word packing.
// Each encoded position searches min(position, WINDOW) distances in S_SCAN, cut short by a
// full-length match. A literal flush emits a header and then each byte read from the history
// RAM; a match token emits two bytes; the block end or abort gives one result word. Each byte
// emitted while the result is held waits.
// Synchronous active-low reset clears control state and sets the capacity to 65535;
// the history RAM and the match chain hold no reset and need no clearing pass.
module lz77_byte_encoder #(
  parameter int WINDOW        = 512,
  parameter int MAX_MATCH     = 10,
  parameter int HISTORY_DEPTH = 1024,
  parameter int LITERAL_RUN   = 128
) (
  input logic          clk,
  input logic          rst_n,
  lzbe_chan_if.sink    in_ch,
  lzbe_chan_if.source  out_ch,
  lzbe_chan_if.sink    cfg_ch
);
  import lzbe_pkg::*;

  localparam int N_CELLS = WINDOW + MAX_MATCH;
  localparam int OFF_W   = $clog2(WINDOW + 1);
  localparam int HA_W    = $clog2(HISTORY_DEPTH);
  localparam int LC_W    = 8;
  localparam int IDX_W   = $clog2(MAX_MATCH);

  lzbe_state_t state_r, state_nxt;
  lzbe_mode_t  mode_r;

  logic [15:0]      cap_r;
  logic [15:0]      bp_r;
  len_t             la_cnt_r;
  logic [HA_W-1:0]  wp_r;
  logic [HA_W-1:0]  run_head_r;
  logic [LC_W-1:0]  lit_cnt_r;
  logic [LC_W-1:0]  idx_r;
  logic [15:0]      emitted_r;
  logic [63:0]      pack_r;
  logic [3:0]       fill_r;
  logic             aborted_r;
  logic             last_r;
  logic [OFF_W-1:0] off_r;
  logic [OFF_W-1:0] search_r;
  len_t             best_r;
  logic [OFF_W-1:0] top_off_r;

  logic        out_valid_r;
  logic [63:0] out_word_r;
  logic [3:0]  out_cnt_r;
  logic        out_done_r;
  logic        out_ovf_r;
  logic [15:0] out_total_r;

  logic        accept;
  logic        out_free;
  logic        emit_en;
  logic [7:0]  emit_val;
  logic        res_fin;
  logic        res_fail;
  logic        clear_blk;
  logic        take_byte;
  logic [15:0] ip;
  logic [OFF_W-1:0] search;
  logic [HA_W:0]    ring_ip;
  logic [HA_W:0]    raddr_sum;
  logic [HA_W-1:0]  raddr;
  logic [7:0]  ram_rdata;
  logic [11:0] tok_off;
  logic [16:0] need_lit;
  logic [16:0] need_tok;
  cell_ctl_t   cell_ctl;

  logic [7:0] cell_byte [N_CELLS];
  len_t       cell_len  [N_CELLS];
  logic [MAX_MATCH-1:0][7:0] la_src;
  logic [MAX_MATCH-1:0][7:0] la_bytes;
  len_t la_sel;

  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign take_byte = accept && !aborted_r && (bp_r != POS_LIMIT);
  assign ip        = bp_r - 16'(la_cnt_r);
  assign search    = (ip < 16'(WINDOW)) ? OFF_W'(ip) : OFF_W'(WINDOW);
  assign ring_ip   = ({1'b0, wp_r} >= (HA_W+1)'(la_cnt_r)) ?
                     ({1'b0, wp_r} - (HA_W+1)'(la_cnt_r)) :
                     ({1'b0, wp_r} + (HA_W+1)'(HISTORY_DEPTH) - (HA_W+1)'(la_cnt_r));
  assign raddr_sum = {1'b0, run_head_r} + (HA_W+1)'(idx_r);
  assign raddr     = (raddr_sum >= (HA_W+1)'(HISTORY_DEPTH)) ?
                     HA_W'(raddr_sum - (HA_W+1)'(HISTORY_DEPTH)) : HA_W'(raddr_sum);
  assign tok_off   = 12'(top_off_r - OFF_W'(1));
  assign need_lit  = 17'(emitted_r) + 17'(lit_cnt_r) + 17'd1;
  assign need_tok  = 17'(emitted_r) + 17'd2;

  assign cell_ctl.load       = (state_r == S_LOAD);
  assign cell_ctl.shift_len  = (state_r == S_SCAN);
  assign cell_ctl.shift_byte = take_byte;
  assign cell_ctl.avail      = la_cnt_r;

  lzbe_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (take_byte),
    .waddr (wp_r),
    .wdata (in_ch.data.data_byte),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  for (genvar m = 0; m < MAX_MATCH; m++) begin : g_la
    assign la_src[m] = cell_byte[m];
  end

  always_comb begin
    la_sel = '0;
    for (int m = 0; m < MAX_MATCH; m++) begin
      la_sel = la_cnt_r - LEN_W'(m) - LEN_W'(1);
      la_bytes[m] = (LEN_W'(m) < la_cnt_r) ? la_src[la_sel[IDX_W-1:0]] : 8'h00;
    end
  end

  for (genvar j = 0; j < N_CELLS; j++) begin : g_cell
    logic [MAX_MATCH-1:0][7:0] taps;
    logic [7:0] b_in;
    len_t       l_in;
    for (genvar k = 0; k < MAX_MATCH; k++) begin : g_tap
      if (j + 1 + k < N_CELLS) begin : g_on
        assign taps[k] = cell_byte[j+1+k];
      end else begin : g_off
        assign taps[k] = 8'h00;
      end
    end
    if (j == 0) begin : g_head
      assign b_in = in_ch.data.data_byte;
    end else begin : g_body
      assign b_in = cell_byte[j-1];
    end
    if (j == N_CELLS - 1) begin : g_tail
      assign l_in = '0;
    end else begin : g_next
      assign l_in = cell_len[j+1];
    end
    lzbe_cell #(.MAX_MATCH(MAX_MATCH)) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .byte_in  (b_in),
      .la       (la_bytes),
      .taps     (taps),
      .len_in   (l_in),
      .byte_out (cell_byte[j]),
      .len_out  (cell_len[j])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !aborted_r) begin
          state_nxt = (bp_r == POS_LIMIT) ? S_FAIL : S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (la_cnt_r == LEN_W'(MAX_MATCH) || (last_r && la_cnt_r != '0)) begin
          state_nxt = S_LOAD;
        end else if (last_r) begin
          state_nxt = (lit_cnt_r != '0) ? S_FL_CHK : S_FIN_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: state_nxt = (search == '0) ? S_ENC : S_SCAN;
      S_SCAN: begin
        if ((cell_len[0] > best_r && cell_len[0] == LEN_W'(MAX_MATCH)) || off_r == search_r) begin
          state_nxt = S_ENC;
        end
      end
      S_ENC: begin
        if (best_r >= MIN_LEN) begin
          state_nxt = (lit_cnt_r != '0) ? S_FL_CHK : S_TK_CHK;
        end else if (9'(lit_cnt_r) + 9'd1 >= 9'(LITERAL_RUN)) begin
          state_nxt = S_FL_CHK;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_FL_CHK: state_nxt = (need_lit > 17'(cap_r)) ? S_FAIL : S_FL_HDR;
      S_FL_HDR: if (emit_en) state_nxt = S_FL_RD;
      S_FL_RD:  state_nxt = S_FL_EM;
      S_FL_EM: begin
        if (emit_en) begin
          if (idx_r + LC_W'(1) == lit_cnt_r) begin
            unique case (mode_r)
              MODE_MATCH: state_nxt = S_TK_CHK;
              MODE_RUN:   state_nxt = S_DECIDE;
              MODE_FINAL: state_nxt = S_FIN_OUT;
              default:    state_nxt = S_IDLE;
            endcase
          end else begin
            state_nxt = S_FL_RD;
          end
        end
      end
      S_TK_CHK:  state_nxt = (need_tok > 17'(cap_r)) ? S_FAIL : S_TK0;
      S_TK0:     if (emit_en) state_nxt = S_TK1;
      S_TK1:     if (emit_en) state_nxt = S_DECIDE;
      S_FIN_OUT: if (out_free) state_nxt = S_IDLE;
      S_FAIL:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit_en  = 1'b0;
    emit_val = 8'h00;
    unique case (state_r)
      S_FL_HDR: begin
        emit_en  = out_free;
        emit_val = lit_cnt_r - LC_W'(1);
      end
      S_FL_EM: begin
        emit_en  = out_free;
        emit_val = ram_rdata;
      end
      S_TK0: begin
        emit_en  = out_free;
        emit_val = TOKEN_FLAG | {1'b0, 3'(best_r - MIN_LEN), 4'h0} | {4'h0, tok_off[11:8]};
      end
      S_TK1: begin
        emit_en  = out_free;
        emit_val = tok_off[7:0];
      end
      default: begin
        emit_en  = 1'b0;
        emit_val = 8'h00;
      end
    endcase
    res_fin   = (state_r == S_FIN_OUT) && out_free;
    res_fail  = (state_r == S_FAIL) && out_free;
    clear_blk = (accept && aborted_r && in_ch.data.last_byte) || res_fin || (res_fail && last_r);
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = '{out_word: out_word_r, byte_count: out_cnt_r, block_done: out_done_r,
                          overflow: out_ovf_r, total_length: out_total_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_RUN;
      cap_r       <= 16'hFFFF;
      bp_r        <= '0;
      la_cnt_r    <= '0;
      wp_r        <= '0;
      lit_cnt_r   <= '0;
      emitted_r   <= '0;
      pack_r      <= '0;
      fill_r      <= '0;
      aborted_r   <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        cap_r <= cfg_ch.data.output_capacity;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        last_r <= in_ch.data.last_byte;
      end
      if (take_byte) begin
        bp_r     <= bp_r + 16'd1;
        la_cnt_r <= la_cnt_r + LEN_W'(1);
        wp_r     <= (wp_r == HA_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + HA_W'(1);
      end
      if (state_r == S_LOAD) begin
        off_r     <= OFF_W'(1);
        best_r    <= '0;
        top_off_r <= '0;
        search_r  <= search;
      end
      if (state_r == S_SCAN) begin
        if (cell_len[0] > best_r) begin
          best_r    <= cell_len[0];
          top_off_r <= off_r;
        end
        off_r <= off_r + OFF_W'(1);
      end
      if (state_r == S_DECIDE && state_nxt != S_LOAD && last_r) begin
        mode_r <= MODE_FINAL;
      end
      if (state_r == S_ENC) begin
        if (best_r >= MIN_LEN) begin
          mode_r <= MODE_MATCH;
        end else begin
          mode_r <= MODE_RUN;
          if (lit_cnt_r == '0) begin
            run_head_r <= HA_W'(ring_ip);
          end
          lit_cnt_r <= lit_cnt_r + LC_W'(1);
          la_cnt_r  <= la_cnt_r - LEN_W'(1);
        end
      end
      if (state_r == S_FL_CHK) begin
        idx_r <= '0;
      end
      if (state_r == S_FL_EM && emit_en) begin
        idx_r <= idx_r + LC_W'(1);
        if (idx_r + LC_W'(1) == lit_cnt_r) begin
          lit_cnt_r <= '0;
        end
      end
      if (state_r == S_TK1 && emit_en) begin
        la_cnt_r <= la_cnt_r - best_r;
      end
      if (emit_en) begin
        emitted_r <= emitted_r + 16'd1;
        if (fill_r == 4'd7) begin
          out_valid_r <= 1'b1;
          out_word_r  <= pack_r | ({56'h0, emit_val} << 56);
          out_cnt_r   <= 4'd8;
          out_done_r  <= 1'b0;
          out_ovf_r   <= 1'b0;
          out_total_r <= emitted_r + 16'd1;
          pack_r      <= '0;
          fill_r      <= '0;
        end else begin
          pack_r <= pack_r | ({56'h0, emit_val} << {fill_r[2:0], 3'b000});
          fill_r <= fill_r + 4'd1;
        end
      end
      if (res_fin) begin
        out_valid_r <= 1'b1;
        out_word_r  <= pack_r;
        out_cnt_r   <= fill_r;
        out_done_r  <= 1'b1;
        out_ovf_r   <= 1'b0;
        out_total_r <= emitted_r;
      end
      if (res_fail) begin
        out_valid_r <= 1'b1;
        out_word_r  <= '0;
        out_cnt_r   <= '0;
        out_done_r  <= 1'b1;
        out_ovf_r   <= 1'b1;
        out_total_r <= emitted_r;
        if (!last_r) begin
          aborted_r <= 1'b1;
        end
      end
      if (clear_blk) begin
        bp_r      <= '0;
        la_cnt_r  <= '0;
        lit_cnt_r <= '0;
        emitted_r <= '0;
        pack_r    <= '0;
        fill_r    <= '0;
        aborted_r <= 1'b0;
      end
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_r < 4'd8)
    else $error("pack fill out of range");
  a_la: assert property (@(posedge clk) disable iff (!rst_n) la_cnt_r <= LEN_W'(MAX_MATCH))
    else $error("lookahead count out of range");
  a_lit: assert property (@(posedge clk) disable iff (!rst_n)
      9'(lit_cnt_r) <= 9'(LITERAL_RUN))
    else $error("literal run too long");
  a_scan: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_SCAN |-> off_r <= search_r && search_r != '0)
    else $error("scan past search limit");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
      emit_en |-> !out_valid_r || out_ch.ready)
    else $error("byte emitted while result stalled");
endmodule

// File: src/lzbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: src/lzbe_cell.sv
// Match cell: one history byte of the shift line and the match length at one distance.
module lzbe_cell #(
  parameter int MAX_MATCH = 10
) (
  input  logic                        clk,
  input  lzbe_pkg::cell_ctl_t         ctl,
  input  logic [7:0]                  byte_in,
  input  logic [MAX_MATCH-1:0][7:0]   la,
  input  logic [MAX_MATCH-1:0][7:0]   taps,
  input  lzbe_pkg::len_t              len_in,
  output logic [7:0]                  byte_out,
  output lzbe_pkg::len_t              len_out
);
  import lzbe_pkg::*;

  localparam int IDX_W = $clog2(MAX_MATCH);

  logic [7:0] byte_r;
  len_t       len_r;
  len_t       len_nxt;
  len_t       run_len;
  len_t       sel;
  logic       run;

  always_comb begin
    run     = 1'b1;
    run_len = '0;
    sel     = '0;
    for (int m = 0; m < MAX_MATCH; m++) begin
      if (run && (LEN_W'(m) < ctl.avail)) begin
        sel = ctl.avail - LEN_W'(m) - LEN_W'(1);
        if (taps[sel[IDX_W-1:0]] == la[m]) begin
          run_len = run_len + LEN_W'(1);
        end else begin
          run = 1'b0;
        end
      end else begin
        run = 1'b0;
      end
    end
    len_nxt = (run_len >= MIN_LEN) ? run_len : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      byte_r <= byte_in;
    end
    if (ctl.load) begin
      len_r <= len_nxt;
    end else if (ctl.shift_len) begin
      len_r <= len_in;
    end
  end

  assign byte_out = byte_r;
  assign len_out  = len_r;
endmodule
